// ===== sv/iscp_pkg.sv =====
// Package for the issuer script command parser: parse phases, status codes,
// tag and class constants, and the result queue entry type. No dependencies.
package iscp_pkg;

    // Parse phase of the script walker
    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_IDTAG = 3'd1,
        PH_IDVAL = 3'd2,
        PH_LEN   = 3'd3,
        PH_CLA   = 3'd4,
        PH_INS   = 3'd5,
        PH_BODY  = 3'd6
    } t_phase;

    // Verdict status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_BAD_TAG   = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_BAD_CLASS = 3'd5;
    localparam logic [2:0] ST_MISMATCH  = 3'd6;
    localparam logic [2:0] ST_TOO_MANY  = 3'd7;

    // Tag bytes
    localparam logic [7:0] TAG_ID_HI  = 8'h9F;
    localparam logic [7:0] TAG_ID_LO  = 8'h18;
    localparam logic [7:0] TAG_CMD    = 8'h86;

    // Class and instruction bytes
    localparam logic [7:0] INS_1E     = 8'h1E;
    localparam logic [7:0] INS_18     = 8'h18;
    localparam logic [7:0] INS_16     = 8'h16;
    localparam logic [7:0] INS_24     = 8'h24;
    localparam logic [7:0] INS_DA     = 8'hDA;
    localparam logic [7:0] INS_DC     = 8'hDC;
    localparam logic [7:0] CLA_SECURE = 8'h84;
    localparam logic [7:0] CLA_PLAIN  = 8'h04;

    // Header: length byte plus four identifier bytes
    localparam logic [7:0] ID_HDR_BYTES = 8'd5;
    localparam logic [7:0] MIN_CMD_LEN  = 8'd4;

    // One queued transfer; a command and a verdict may share an entry
    typedef struct packed {
        logic        has_cmd;
        logic        has_vrd;
        logic [2:0]  cmd_index;
        logic [6:0]  cmd_offset;
        logic [6:0]  cmd_length;
        logic [2:0]  status;
        logic [31:0] script_id;
        logic        id_present;
        logic [2:0]  command_total;
    } t_entry;

    function automatic logic class_ok(input logic [7:0] cla, input logic [7:0] ins);
        logic ok;
        ok = 1'b1;
        if (ins == INS_1E || ins == INS_18 || ins == INS_16 || ins == INS_24) begin
            ok = (cla == CLA_SECURE);
        end else if (ins == INS_DA || ins == INS_DC) begin
            ok = (cla == CLA_PLAIN);
        end
        return ok;
    endfunction

endpackage

// ===== sv/issuer_script_command_parser_core.sv =====
// Issuer script command parser: walks a tag-86 issuer script byte by byte,
// reports each command and a final verdict. Depends on iscp_pkg.
//
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] script byte, tlast end of script
// m_axis   | out       | tdata 56 bits (see port), tuser kind, tlast verdict
//
// Cycles: one script byte is taken per cycle while the queue has room; the
// parse is a single combinational pass from the accepted byte and the walker
// registers into the walker registers and a two-entry result queue.
// A byte that yields both a command and the verdict occupies one queue entry
// and leaves in two output transfers.
// Stalls: s_axis_tready drops only while both queue entries are full.
// Reset: synchronous, active low; clears walker state and the queue.
module issuer_script_command_parser_core #(
    parameter int MAX_SCRIPT_BYTES = 128,
    parameter int MAX_COMMANDS     = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] script_byte
    input  logic        s_axis_tlast,   // end_of_script
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] cmd_index, [9:3] cmd_offset, [16:10] cmd_length, [19:17] status,
    // [51:20] script_id, [52] id_present, [55:53] command_total
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind: 0 command, 1 verdict
    output logic        m_axis_tlast    // last
);
    import iscp_pkg::*;

    localparam int CW = $clog2(MAX_COMMANDS + 1);

    // Walker state
    logic [7:0]    r_pos,   n_pos;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_left,  n_left;
    logic [7:0]    r_cla,   n_cla;
    logic [6:0]    r_start, n_start;
    logic [6:0]    r_len,   n_len;
    logic [CW-1:0] r_seen,  n_seen;
    logic [31:0]   r_id,    n_id;
    logic          r_idf,   n_idf;
    logic [2:0]    r_err,   n_err;
    logic          r_over,  n_over;

    // Result queue
    t_entry        r_fifo [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count;
    logic          r_phase2;

    logic          in_xfer;
    logic          out_xfer;
    logic          pop;
    logic          push;
    t_entry        n_entry;
    t_entry        head;
    logic [2:0]    vrd_status;

    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (r_count != 2'd2);

    // Parse one byte
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_left  = r_left;
        n_cla   = r_cla;
        n_start = r_start;
        n_len   = r_len;
        n_seen  = r_seen;
        n_id    = r_id;
        n_idf   = r_idf;
        n_err   = r_err;
        n_over  = r_over;
        n_entry = '0;
        vrd_status = ST_OK;

        if (in_xfer) begin
            // Stop the byte count once the limit is passed
            if (r_pos >= 8'(MAX_SCRIPT_BYTES)) begin
                n_over = 1'b1;
            end else begin
                n_pos = r_pos + 8'd1;
            end

            if (r_err == ST_OK) begin
                unique case (r_phase)
                    PH_TAG: begin
                        if (r_pos == 8'd0 && s_axis_tdata == TAG_ID_HI) begin
                            n_phase = PH_IDTAG;
                        end else if (s_axis_tdata != TAG_CMD) begin
                            n_err = ST_BAD_TAG;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_IDTAG: begin
                        if (s_axis_tdata != TAG_ID_LO) begin
                            n_err = ST_BAD_ID;
                        end else begin
                            n_idf   = 1'b1;
                            n_left  = ID_HDR_BYTES;
                            n_phase = PH_IDVAL;
                        end
                    end
                    PH_IDVAL: begin
                        // Skip the header length byte, shift in the four id bytes
                        if (r_left < ID_HDR_BYTES) begin
                            n_id = {r_id[23:0], s_axis_tdata};
                        end
                        if (r_left != 8'd0) begin
                            n_left = r_left - 8'd1;
                        end
                        if (n_left == 8'd0) begin
                            n_phase = PH_TAG;
                        end
                    end
                    PH_LEN: begin
                        if (s_axis_tdata < MIN_CMD_LEN || s_axis_tdata[7]) begin
                            n_err = ST_SHORT;
                        end else begin
                            n_len   = s_axis_tdata[6:0];
                            n_start = r_pos[6:0] + 7'd1;
                            n_left  = s_axis_tdata;
                            n_phase = PH_CLA;
                        end
                    end
                    PH_CLA: begin
                        n_cla   = s_axis_tdata;
                        n_left  = r_left - 8'd1;
                        n_phase = PH_INS;
                    end
                    PH_INS: begin
                        if (!class_ok(r_cla, s_axis_tdata)) begin
                            n_err = ST_BAD_CLASS;
                        end else if (r_seen >= CW'(MAX_COMMANDS)) begin
                            n_err = ST_TOO_MANY;
                        end else begin
                            n_entry.has_cmd    = 1'b1;
                            n_entry.cmd_index  = 3'(r_seen);
                            n_entry.cmd_offset = r_start;
                            n_entry.cmd_length = r_len;
                            n_seen  = r_seen + CW'(1);
                            n_left  = r_left - 8'd1;
                            n_phase = (n_left == 8'd0) ? PH_TAG : PH_BODY;
                        end
                    end
                    default: begin
                        if (r_left != 8'd0) begin
                            n_left = r_left - 8'd1;
                        end
                        if (n_left == 8'd0) begin
                            n_phase = PH_TAG;
                        end
                    end
                endcase
            end

            n_entry.script_id  = n_id;
            n_entry.id_present = n_idf;

            if (s_axis_tlast) begin
                priority if (n_err == ST_BAD_ID) begin
                    vrd_status = ST_BAD_ID;
                end else if (n_over) begin
                    vrd_status = ST_TOO_LONG;
                end else if (n_err != ST_OK) begin
                    vrd_status = n_err;
                end else if (n_phase != PH_TAG) begin
                    vrd_status = ST_MISMATCH;
                end else begin
                    vrd_status = ST_OK;
                end
                n_entry.has_vrd       = 1'b1;
                n_entry.status        = vrd_status;
                n_entry.command_total = 3'(n_seen);

                // Back to reset state for the next script
                n_pos   = '0;
                n_phase = PH_TAG;
                n_left  = '0;
                n_cla   = '0;
                n_start = '0;
                n_len   = '0;
                n_seen  = '0;
                n_id    = '0;
                n_idf   = 1'b0;
                n_err   = ST_OK;
                n_over  = 1'b0;
            end
        end
    end

    assign push = in_xfer & (n_entry.has_cmd | n_entry.has_vrd);

    // Output view of the queue head: command part first, then verdict part
    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_count != 2'd0);
    assign out_xfer      = m_axis_tvalid & m_axis_tready;
    assign pop           = out_xfer & (~(head.has_cmd & head.has_vrd) | r_phase2);

    always_comb begin
        if (head.has_cmd && !r_phase2) begin
            m_axis_tuser = 1'b0;
            m_axis_tlast = 1'b0;
            m_axis_tdata = {3'd0, head.id_present, head.script_id, ST_OK,
                            head.cmd_length, head.cmd_offset, head.cmd_index};
        end else begin
            m_axis_tuser = 1'b1;
            m_axis_tlast = 1'b1;
            m_axis_tdata = {head.command_total, head.id_present, head.script_id,
                            head.status, 7'd0, 7'd0, 3'd0};
        end
    end

    // Walker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_TAG;
            r_left  <= '0;
            r_cla   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_seen  <= '0;
            r_id    <= '0;
            r_idf   <= 1'b0;
            r_err   <= ST_OK;
            r_over  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_cla   <= n_cla;
            r_start <= n_start;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_id    <= n_id;
            r_idf   <= n_idf;
            r_err   <= n_err;
            r_over  <= n_over;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_entry;
        end
    end

    // Queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_phase2 <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_phase2 <= 1'b0;
            end else if (out_xfer) begin
                // Command half of a shared entry went out; hold for the verdict
                r_phase2 <= 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
